// ===== sv/ftrl_pkg.sv =====
// Package with the item types and fixed constants of the FTRL weight update unit.
package ftrl_pkg;

  // One input item.
  typedef struct packed {
    logic               op;
    logic [11:0]        feature;
    logic signed [31:0] gradient;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] weight;
    logic               saturated;
  } out_item_t;

  // One table entry: accumulator, squared-gradient sum and weight.
  typedef struct packed {
    logic signed [31:0] z;
    logic [47:0]        n;
    logic signed [31:0] w;
  } entry_t;

  // Operation codes.
  localparam logic OP_RECOMPUTE = 1'b0;
  localparam logic OP_GRADIENT  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_L1    = 2'd2;
  localparam logic [1:0] REG_L2    = 2'd3;

  // Width of the shared divider operands.
  localparam int unsigned DivW = 50;

  // Caps and limits.
  localparam logic [40:0] MagCap = 41'h100_0000_0000;
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

endpackage

// ===== sv/ftrl_table_mem.sv =====
// Synchronous single-write, single-read table memory with registered read data.
module ftrl_table_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  ftrl_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output ftrl_pkg::entry_t rdata_o
);
  import ftrl_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ftrl_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module ftrl_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  // One digit of the restoring root recurrence.
  assign rem_sh = {rem_q[31:0], val_q[63:62]};
  assign trial  = {root_q, 2'b01};

  // Control: count 32 steps after start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sv/ftrl_div.sv =====
// Iterative restoring unsigned divider, one quotient bit per cycle.
module ftrl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ftrl_pkg::DivW-1:0]  dividend_i,
  input  logic [ftrl_pkg::DivW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ftrl_pkg::DivW-1:0]  quotient_o
);
  import ftrl_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW:0]   rem_q;
  logic [DivW-1:0] quo_q;
  logic [DivW-1:0] dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DivW:0]   rem_sh;

  assign rem_sh = {rem_q[DivW-1:0], quo_q[DivW-1]};

  // Control: DivW steps after start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of the quotient register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_q <= rem_sh - {1'b0, dsr_q};
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/ftrl_proximal_weight_update_unit.sv =====
// Top level of the FTRL-proximal weight update unit: control, datapath and table.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (op, feature, gradient)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (weight, saturated)
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item at a time: the index is folded and the table read, then op 0 uses at
// most one root and two divisions and op 1 two roots and one division; the
// serial root and divider set the pace.
// After reset a clearing pass writes FEATURES entries, one per cycle, with in_stall_o high.
// A result waits in the output register; the next one waits in ST_OUT until it is taken.
module ftrl_proximal_weight_update_unit #(
  parameter int unsigned FEATURES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ftrl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ftrl_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import ftrl_pkg::*;

  localparam int unsigned AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  // State codes.
  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_MOD   = 5'd2;
  localparam logic [4:0] ST_READ  = 5'd3;
  localparam logic [4:0] ST_LOAD  = 5'd4;
  localparam logic [4:0] ST_Z0    = 5'd5;
  localparam logic [4:0] ST_SQ0   = 5'd6;
  localparam logic [4:0] ST_DV1   = 5'd7;
  localparam logic [4:0] ST_DV2   = 5'd8;
  localparam logic [4:0] ST_WSET  = 5'd9;
  localparam logic [4:0] ST_GG    = 5'd10;
  localparam logic [4:0] ST_N1    = 5'd11;
  localparam logic [4:0] ST_SQA   = 5'd12;
  localparam logic [4:0] ST_SQB   = 5'd13;
  localparam logic [4:0] ST_DVS   = 5'd14;
  localparam logic [4:0] ST_ML    = 5'd15;
  localparam logic [4:0] ST_MH    = 5'd16;
  localparam logic [4:0] ST_MS    = 5'd17;
  localparam logic [4:0] ST_ZN    = 5'd18;
  localparam logic [4:0] ST_WR    = 5'd19;
  localparam logic [4:0] ST_OUT   = 5'd20;

  logic [4:0]  state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [3:0]  k_q;

  logic [31:0] alpha_q, beta_q, l1_q, l2_q;

  logic               op_q;
  logic [11:0]        fidx_q;
  logic signed [31:0] grad_q;
  logic signed [31:0] z_q;
  logic [47:0]        n_q;
  logic signed [31:0] w_q;
  logic               sat_q;
  logic [47:0]        gg_q;
  logic [31:0]        root0_q;
  logic [40:0]        mag_q;
  logic [55:0]        plo_q, phi_q;
  logic [40:0]        m_q;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic        in_acc;
  logic        out_free;
  logic [AW-1:0] addr;
  logic [32:0] mod_sub;
  logic [31:0] alpha_eff;
  logic [31:0] az;
  logic [31:0] aw;
  logic [31:0] ag;
  logic [63:0] ag_sq;
  logic [48:0] n_sum;
  logic [DivW-1:0] den;
  logic [79:0] prod;
  logic [63:0] prod_sh;
  logic signed [42:0] zn;

  logic            sq_start, sq_done;
  logic [63:0]     sq_value;
  logic [31:0]     sq_root;
  logic            dv_start, dv_done;
  logic [DivW-1:0] dv_dividend, dv_divisor, dv_quo;

  logic   mem_we;
  entry_t mem_wdata, mem_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign addr       = AW'(fidx_q);
  assign mod_sub    = 33'(FEATURES) << k_q;
  assign alpha_eff  = (alpha_q == 32'd0) ? 32'd1 : alpha_q;

  // Magnitudes and sums used across the steps.
  assign az      = z_q[31] ? 32'(-z_q) : 32'(z_q);
  assign aw      = w_q[31] ? 32'(-w_q) : 32'(w_q);
  assign ag      = grad_q[31] ? 32'(-grad_q) : 32'(grad_q);
  assign ag_sq   = 64'(ag) * 64'(ag);
  assign n_sum   = {1'b0, n_q} + {1'b0, gg_q};
  assign den     = dv_quo + DivW'(l2_q);
  assign prod    = (80'(phi_q) << 24) + 80'(plo_q);
  assign prod_sh = prod[79:16];
  assign zn      = 43'(z_q) + 43'(grad_q) +
                   ((w_q > 0) ? -$signed({2'b00, m_q}) : $signed({2'b00, m_q}));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 32'd6554;
      beta_q  <= 32'd65536;
      l1_q    <= 32'd65536;
      l2_q    <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA: alpha_q <= cfg_data_i;
        REG_BETA:  beta_q  <= cfg_data_i;
        REG_L1:    l1_q    <= cfg_data_i;
        REG_L2:    l2_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Sequencer: next state and unit starts.
  always_comb begin
    state_d     = state_q;
    sq_start    = 1'b0;
    sq_value    = {n_q, 16'h0000};
    dv_start    = 1'b0;
    dv_dividend = DivW'({33'(beta_q) + 33'(sq_root), 16'h0000});
    dv_divisor  = DivW'(alpha_eff);
    mem_we      = 1'b0;
    mem_wdata   = '{z: z_q, n: n_q, w: w_q};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (clr_q == AW'(FEATURES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE:  if (in_valid_i) state_d = ST_MOD;
      ST_MOD:   if (k_q == 4'd0) state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = (op_q == OP_RECOMPUTE) ? ST_Z0 : ST_GG;
      ST_Z0: begin
        if (az > l1_q) begin
          sq_start = 1'b1;
          state_d  = ST_SQ0;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_SQ0: begin
        if (sq_done) begin
          dv_start = 1'b1;
          state_d  = ST_DV1;
        end
      end
      ST_DV1: begin
        dv_dividend = DivW'({az - l1_q, 16'h0000});
        dv_divisor  = den;
        if (dv_done) begin
          dv_start = (den != '0);
          state_d  = (den != '0) ? ST_DV2 : ST_WSET;
        end
      end
      ST_DV2:   if (dv_done) state_d = ST_WSET;
      ST_WSET:  state_d = ST_WR;
      ST_GG: begin
        sq_start = 1'b1;
        state_d  = ST_N1;
      end
      ST_N1:    state_d = ST_SQA;
      ST_SQA: begin
        if (sq_done) begin
          sq_start = 1'b1;
          state_d  = ST_SQB;
        end
      end
      ST_SQB: begin
        dv_dividend = DivW'({sq_root - root0_q, 16'h0000});
        if (sq_done) begin
          dv_start = 1'b1;
          state_d  = ST_DVS;
        end
      end
      ST_DVS:   if (dv_done) state_d = ST_ML;
      ST_ML:    state_d = ST_MH;
      ST_MH:    state_d = ST_MS;
      ST_MS:    state_d = ST_ZN;
      ST_ZN:    state_d = ST_WR;
      ST_WR: begin
        mem_we  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (in_acc) k_q <= 4'd11;
      else if (state_q == ST_MOD && k_q != 4'd0) k_q <= k_q - 4'd1;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q   <= in_item_i.op;
        fidx_q <= in_item_i.feature;
        grad_q <= in_item_i.gradient;
        sat_q  <= 1'b0;
      end
      // Fold the index below the table depth, one restoring step a cycle.
      ST_MOD: if ({21'h0, fidx_q} >= mod_sub) fidx_q <= fidx_q - mod_sub[11:0];
      ST_LOAD: begin
        z_q <= mem_rdata.z;
        n_q <= mem_rdata.n;
        w_q <= mem_rdata.w;
      end
      ST_Z0: if (!(az > l1_q)) w_q <= '0;
      ST_DV1: begin
        if (dv_done && den == '0) begin
          mag_q <= MagCap;
          sat_q <= 1'b1;
        end
      end
      ST_DV2: if (dv_done) mag_q <= (dv_quo > DivW'(MagCap)) ? MagCap : 41'(dv_quo);
      // Sign and clamp of the new weight.
      ST_WSET: begin
        if (z_q > 0) begin
          if (mag_q > 41'h0_8000_0000) begin
            w_q   <= 32'sh8000_0000;
            sat_q <= 1'b1;
          end else begin
            w_q <= 32'(-$signed({1'b0, mag_q}));
          end
        end else begin
          if (mag_q > 41'h0_7FFF_FFFF) begin
            w_q   <= 32'sh7FFF_FFFF;
            sat_q <= 1'b1;
          end else begin
            w_q <= 32'(mag_q);
          end
        end
      end
      ST_GG: gg_q <= ag_sq[63:16];
      ST_N1: begin
        if (n_sum[48]) begin
          n_q   <= SumMax;
          sat_q <= 1'b1;
        end else begin
          n_q <= n_sum[47:0];
        end
      end
      ST_SQA: if (sq_done) root0_q <= sq_root;
      ST_ML:  plo_q <= 56'(dv_quo[23:0]) * 56'(aw);
      ST_MH:  phi_q <= 56'(dv_quo[47:24]) * 56'(aw);
      ST_MS:  m_q <= (prod_sh > 64'(MagCap)) ? MagCap : 41'(prod_sh);
      ST_ZN: begin
        if (zn > 43'sh7FFF_FFFF) begin
          z_q   <= 32'sh7FFF_FFFF;
          sat_q <= 1'b1;
        end else if (zn < -43'sh8000_0000) begin
          z_q   <= 32'sh8000_0000;
          sat_q <= 1'b1;
        end else begin
          z_q <= 32'(zn);
        end
      end
      ST_OUT: if (out_free) out_item_q <= '{weight: w_q, saturated: sat_q};
      default: ;
    endcase
  end

  // Shared root and divider units.
  ftrl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_value),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  ftrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .done_o     (dv_done),
    .quotient_o (dv_quo)
  );

  // Feature table.
  ftrl_table_mem #(
    .DEPTH (FEATURES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ((state_q == ST_CLEAR) ? clr_q : addr),
    .wdata_i (mem_wdata),
    .raddr_i (addr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The table is written only by the clearing pass or the write-back step.
  a_mem_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_WR))
    else $error("table written outside clear or write-back");

  // An accepted item always starts with the index fold.
  a_accept_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MOD && k_q == 4'd11))
    else $error("accepted item did not enter index fold");

  // The root unit reports completion only while the sequencer waits for it.
  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQ0 || state_q == ST_SQA || state_q == ST_SQB))
    else $error("root result arrived in an unexpected state");

  // The divider reports completion only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == ST_DV1 || state_q == ST_DV2 || state_q == ST_DVS))
    else $error("divider result arrived in an unexpected state");

endmodule

// ===== tb/sv/ftrl_update_checker.sv =====
// Checker that predicts and compares the results of the FTRL weight update unit.
`timescale 1ns / 100ps

module ftrl_update_checker #(
  parameter int unsigned FEATURES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ftrl_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ftrl_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output int                  fail_count_o
);
  import ftrl_pkg::*;

  localparam longint SignedMax = 64'sd2147483647;
  localparam longint SignedMin = -64'sd2147483648;
  localparam logic [63:0] TermCap = 64'h100_0000_0000;

  // Shadow copy of the feature table and of the registers.
  longint      acc_z [FEATURES];
  logic [47:0] sq_sum [FEATURES];
  longint      wt [FEATURES];
  logic [63:0] alpha_q, beta_q, l1_q, l2_q;

  out_item_t weight_results_q[$];

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < FEATURES; i++) begin
      acc_z[i]  = 0;
      sq_sum[i] = '0;
      wt[i]     = 0;
    end
    alpha_q = 64'd6554;
    beta_q  = 64'd65536;
    l1_q    = 64'd65536;
    l2_q    = 64'd65536;
  end

  // Integer square root, bit by bit from the top.
  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root of an unsigned Q32.16 sum as unsigned Q16.16.
  function automatic logic [63:0] sum_root(logic [47:0] n);
    return int_root({n, 16'h0000});
  endfunction

  function automatic longint clamp_word(longint v, inout logic sat);
    if (v > SignedMax) begin
      sat = 1'b1;
      return SignedMax;
    end
    if (v < SignedMin) begin
      sat = 1'b1;
      return SignedMin;
    end
    return v;
  endfunction

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic out_item_t step_feature(in_item_t it);
    int unsigned f;
    logic        sat;
    longint      z, w, g, zn;
    logic [63:0] ae, az, num, den, mag, ag, gg, n0, n1, sigma, aw, m;
    out_item_t   res;
    f   = it.feature % FEATURES;
    sat = 1'b0;
    z   = acc_z[f];
    ae  = (alpha_q == 0) ? 64'd1 : alpha_q;
    if (it.op == OP_RECOMPUTE) begin
      az = (z < 0) ? -z : z;
      w  = 0;
      if (az > l1_q) begin
        num = az - l1_q;
        den = (((beta_q + sum_root(sq_sum[f])) << 16) / ae) + l2_q;
        if (den == 0) begin
          mag = TermCap;
          sat = 1'b1;
        end else begin
          mag = (num << 16) / den;
          if (mag > TermCap) mag = TermCap;
        end
        w = (z > 0) ? -$signed(mag) : $signed(mag);
        w = clamp_word(w, sat);
      end
      wt[f] = w;
    end else begin
      g  = longint'(it.gradient);
      ag = (g < 0) ? -g : g;
      gg = (ag * ag) >> 16;
      n0 = {16'h0, sq_sum[f]};
      n1 = n0 + gg;
      if (n1 > {16'h0, SumMax}) begin
        n1  = {16'h0, SumMax};
        sat = 1'b1;
      end
      sigma = ((sum_root(n1[47:0]) - sum_root(n0[47:0])) << 16) / ae;
      w  = wt[f];
      aw = (w < 0) ? -w : w;
      if (aw != 0 && sigma > 64'hFFFF_FFFF_FFFF_FFFF / aw) begin
        m = TermCap;
      end else begin
        m = (sigma * aw) >> 16;
        if (m > TermCap) m = TermCap;
      end
      zn = z + g;
      if (w > 0) zn = zn - $signed(m);
      else zn = zn + $signed(m);
      acc_z[f]  = clamp_word(zn, sat);
      sq_sum[f] = n1[47:0];
    end
    res.weight    = wt[f][31:0];
    res.saturated = sat;
    return res;
  endfunction

  // Track register writes, predict accepted items and compare results.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA: alpha_q = {32'h0, cfg_data_i};
          REG_BETA:  beta_q  = {32'h0, cfg_data_i};
          REG_L1:    l1_q    = {32'h0, cfg_data_i};
          default:   l2_q    = {32'h0, cfg_data_i};
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (weight_results_q.size() == 0) begin
          $display("%0t: result with none expected: weight %h sat %b", $time,
                   out_item_i.weight, out_item_i.saturated);
          fail_count_o++;
        end else begin
          want = weight_results_q.pop_front();
          if (out_item_i.weight !== want.weight) begin
            $display("%0t: weight mismatch: expected %h actual %h", $time,
                     want.weight, out_item_i.weight);
            fail_count_o++;
          end
          if (out_item_i.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %b actual %b", $time,
                     want.saturated, out_item_i.saturated);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) weight_results_q.push_back(step_feature(in_item_i));
    end
  end

  // Anything still waiting when the run ends is a failure.
  function automatic int leftover();
    return weight_results_q.size();
  endfunction

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, stimulus, register phases and the verdict.
`timescale 1ns / 100ps

module testbench;
  import ftrl_pkg::*;

  localparam int WatchLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_ALPHA;
  logic [31:0] cfg_data = '0;
  int        fail_count;
  int        items_sent = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        no_idle = 1'b0;

  always #1 clk_i = ~clk_i;

  ftrl_proximal_weight_update_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  ftrl_update_checker u_check (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count)
  );

  // Count results and watch for a stuck block.
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) results_seen++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts unless no_idle is set.
  always @(negedge clk_i) begin
    if (no_idle) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  = 1'b1;
      stall_left = int'($urandom_range(1, 3)) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(logic op, logic [11:0] feature, logic [31:0] gradient);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_item.op       = op;
    in_item.feature  = feature;
    in_item.gradient = gradient;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Drops valid and waits until every result is back.
  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (results_seen < items_sent) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] b, logic [31:0] l1, logic [31:0] l2);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    write_reg(REG_L1, l1);
    write_reg(REG_L2, l2);
  endtask

  // Random items: mostly a few hot features so state builds up.
  task automatic random_items(int count);
    logic [11:0] feature;
    logic [31:0] gradient;
    for (int i = 0; i < count; i++) begin
      feature = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 15)) : 12'($urandom);
      case ($urandom_range(0, 3))
        0: gradient = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        1: gradient = 32'($signed($urandom_range(0, 2000)) - 1000);
        2: gradient = 32'($signed($urandom_range(0, 512 << 16)) - (256 << 16));
        default: gradient = $urandom;
      endcase
      send_item(($urandom_range(0, 2) == 0) ? OP_RECOMPUTE : OP_GRADIENT, feature, gradient);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset register values.
    send_item(OP_RECOMPUTE, 12'd0, 32'h0);
    send_item(OP_GRADIENT, 12'd1, 32'h7FFF_FFFF);
    send_item(OP_GRADIENT, 12'd1, 32'h7FFF_FFFF);  // accumulator clamps
    send_item(OP_RECOMPUTE, 12'd1, 32'h0);
    send_item(OP_GRADIENT, 12'd1, 32'h8000_0000);
    for (int i = 0; i < 5; i++) send_item(OP_GRADIENT, 12'd2, 32'h8000_0000);  // sum clamps
    send_item(OP_RECOMPUTE, 12'd2, 32'hFFFF_FFFF);
    send_item(OP_GRADIENT, 12'd4095, 32'hFFFF_0000);
    send_item(OP_GRADIENT, 12'd4095, 32'hFFFF_0000);
    send_item(OP_RECOMPUTE, 12'd4095, 32'h0);
    send_item(OP_GRADIENT, 12'd4095, 32'h0001_0000);
    drain();

    // Huge alpha and tiny lambda2: the weight overflows, then the denominator is zero.
    set_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1);
    send_item(OP_GRADIENT, 12'd3, 32'h0100_0000);
    send_item(OP_RECOMPUTE, 12'd3, 32'h0);
    send_item(OP_GRADIENT, 12'd5, 32'hFFFF_FF38);
    send_item(OP_RECOMPUTE, 12'd5, 32'h0);
    drain();
    write_reg(REG_L2, 32'h0);
    send_item(OP_RECOMPUTE, 12'd5, 32'h0);
    send_item(OP_GRADIENT, 12'd5, 32'h0000_00C8);
    drain();

    // Random phases over several register settings.
    set_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);  // alpha zero
    random_items(150);
    drain();
    set_regs($urandom_range(1, 1 << 20), $urandom_range(0, 1 << 18),
             $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17));
    random_items(160);
    drain();
    set_regs($urandom, $urandom, $urandom, $urandom);
    random_items(150);
    drain();
    set_regs(32'd6554, 32'd65536, 32'd32768, 32'd0);
    no_idle = 1'b1;
    random_items(170);
    drain();

    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && u_check.leftover() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (u_check.leftover() != 0)
        $display("%0t: %0d expected results never arrived", $time, u_check.leftover());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
